@@ rtl/csl_pkg.sv @@
// Shared types, constants and codes for the channel slot table.
`default_nettype none
package csl_pkg;

  // Pool geometry
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int MAXC_W      = 5;
  localparam int LEN_W       = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int OUT_SLOT_W  = 4;
  localparam int ID_W        = 32;
  localparam int TYPE_W      = 8;

  // Configuration register indexes
  localparam logic REG_REGION_ID   = 1'b0;
  localparam logic REG_REGION_TYPE = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DEL    = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_LIST   = 2'd3
  } func_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_TEST,
    ST_DEL_RD,
    ST_DEL_WR
  } state_t;

  // Kind of result word loaded into the output register
  typedef enum logic [1:0] {
    EMIT_FULL,
    EMIT_MISS,
    EMIT_ADDED,
    EMIT_ENTRY
  } emit_t;

  // Per-slot record kept in the slot RAM
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ctype;
    logic [ID_W-1:0]   rid;
    logic [TYPE_W-1:0] rtype;
  } slot_rec_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  latch;
    logic  do_add;
    logic  idx_clr;
    logic  idx_inc;
    logic  slot_ld;
    logic  rd_last;
    logic  del_commit;
    logic  emit;
    emit_t emit_kind;
    logic  emit_last;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_t func;
    logic  full;
    logic  walk_empty;
    logic  walk_last;
    logic  match;
  } ctl_stat_t;

endpackage
`default_nettype wire

@@ rtl/csl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/csl_ctrl.sv @@
// Controller state machine for the channel slot table.
`default_nettype none
module csl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire csl_pkg::ctl_stat_t  stat,
  output csl_pkg::ctl_cmd_t        cmd,
  output logic                     busy
);

  csl_pkg::state_t state, state_next;
  logic            walk_list;

  assign walk_list = (stat.func == csl_pkg::FUNC_LIST);
  assign busy      = (state != csl_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      csl_pkg::ST_IDLE: begin
        if (start) state_next = csl_pkg::ST_DISPATCH;
      end
      csl_pkg::ST_DISPATCH: begin
        if (stat.func == csl_pkg::FUNC_ADD || stat.walk_empty) begin
          state_next = csl_pkg::ST_IDLE;
        end else begin
          state_next = csl_pkg::ST_FETCH;
        end
      end
      csl_pkg::ST_FETCH: state_next = csl_pkg::ST_TEST;
      csl_pkg::ST_TEST: begin
        if (!walk_list && stat.match) begin
          state_next = (stat.func == csl_pkg::FUNC_DEL) ? csl_pkg::ST_DEL_RD
                                                        : csl_pkg::ST_IDLE;
        end else if (stat.walk_last) begin
          state_next = csl_pkg::ST_IDLE;
        end else begin
          state_next = csl_pkg::ST_FETCH;
        end
      end
      csl_pkg::ST_DEL_RD: state_next = csl_pkg::ST_DEL_WR;
      csl_pkg::ST_DEL_WR: state_next = csl_pkg::ST_IDLE;
      default:            state_next = csl_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd           = '0;
    cmd.emit_kind = csl_pkg::EMIT_MISS;
    case (state)
      csl_pkg::ST_IDLE: begin
        cmd.latch = start;
      end
      csl_pkg::ST_DISPATCH: begin
        if (stat.func == csl_pkg::FUNC_ADD) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (stat.full) begin
            cmd.emit_kind = csl_pkg::EMIT_FULL;
          end else begin
            cmd.do_add    = 1'b1;
            cmd.emit_kind = csl_pkg::EMIT_ADDED;
          end
        end else if (stat.walk_empty) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_kind = csl_pkg::EMIT_MISS;
        end else begin
          // start the walk at used-list position zero
          cmd.idx_clr = 1'b1;
        end
      end
      csl_pkg::ST_FETCH: begin
        cmd.slot_ld = 1'b1;
      end
      csl_pkg::ST_TEST: begin
        if (walk_list) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = csl_pkg::EMIT_ENTRY;
          cmd.emit_last = stat.walk_last;
          cmd.idx_inc   = !stat.walk_last;
        end else if (stat.match) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = csl_pkg::EMIT_ENTRY;
          cmd.emit_last = 1'b1;
        end else if (stat.walk_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = csl_pkg::EMIT_MISS;
          cmd.emit_last = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      csl_pkg::ST_DEL_RD: begin
        cmd.rd_last = 1'b1;
      end
      csl_pkg::ST_DEL_WR: begin
        cmd.del_commit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/csl_dpath.sv @@
// Datapath: free stack, used list, slot records, counters and result register.
`default_nettype none
module csl_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire csl_pkg::ctl_cmd_t           cmd,
  output csl_pkg::ctl_stat_t               stat,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_addr,
  input  wire logic [csl_pkg::ID_W-1:0]    cfg_wdata,
  input  wire logic [1:0]                  func,
  input  wire logic [csl_pkg::ID_W-1:0]    channel_id,
  input  wire logic [csl_pkg::TYPE_W-1:0]  channel_type,
  input  wire logic [csl_pkg::MAXC_W-1:0]  max_count,
  output logic                             valid,
  output logic                             status,
  output logic                             found,
  output logic [csl_pkg::OUT_SLOT_W-1:0]   slot,
  output logic [csl_pkg::ID_W-1:0]         entry_id,
  output logic [csl_pkg::TYPE_W-1:0]       entry_type,
  output logic [csl_pkg::ID_W-1:0]         entry_region_id,
  output logic [csl_pkg::TYPE_W-1:0]       entry_region_type,
  output logic                             last_of_run
);

  localparam int SW = csl_pkg::SLOT_W;
  localparam int CW = csl_pkg::CNT_W;
  localparam int LW = csl_pkg::LEN_W;

  // Configuration registers
  logic [csl_pkg::ID_W-1:0]   region_id;
  logic [csl_pkg::TYPE_W-1:0] region_type;

  // Latched request
  csl_pkg::func_t               func_r;
  logic [csl_pkg::ID_W-1:0]     id_r;
  logic [csl_pkg::TYPE_W-1:0]   type_r;
  logic [csl_pkg::MAXC_W-1:0]   maxc_r;

  // Pool state
  logic [SW-1:0] free_stack [csl_pkg::SLOTS];
  logic [CW-1:0] free_count;
  logic [CW-1:0] used_count;

  // Walk state
  logic [SW-1:0] idx, idx_next;
  logic [SW-1:0] cur_slot;
  logic [LW-1:0] walk_len;
  logic [LW-1:0] list_len;

  // RAM ports
  logic                ul_we;
  logic [SW-1:0]       ul_waddr, ul_wdata, ul_raddr, ul_rdata;
  csl_pkg::slot_rec_t  rec_wdata, rec_rdata;
  logic [SW-1:0]       pop_slot;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_id   <= '0;
      region_type <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == csl_pkg::REG_REGION_ID) begin
        region_id <= cfg_wdata;
      end
      if (cfg_addr == csl_pkg::REG_REGION_TYPE) begin
        region_type <= cfg_wdata[csl_pkg::TYPE_W-1:0];
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= csl_pkg::func_t'(func);
      id_r   <= channel_id;
      type_r <= channel_type;
      maxc_r <= max_count;
    end
  end

  // Walk length: list takes min(max_count, used_count, MAX_RESULTS)
  always_comb begin
    list_len = LW'(maxc_r);
    if (LW'(used_count) < list_len) list_len = LW'(used_count);
    if (LW'(csl_pkg::MAX_RESULTS) < list_len) list_len = LW'(csl_pkg::MAX_RESULTS);
    walk_len = (func_r == csl_pkg::FUNC_LIST) ? list_len : LW'(used_count);
  end

  assign pop_slot = free_stack[SW'(free_count - CW'(1))];

  assign stat.func       = func_r;
  assign stat.full       = (used_count >= CW'(csl_pkg::SLOTS)) || (free_count == '0);
  assign stat.walk_empty = (walk_len == '0);
  assign stat.walk_last  = ((LW'(idx) + LW'(1)) == walk_len);
  assign stat.match      = (rec_rdata.id == id_r);

  // Walk index
  always_comb begin
    idx_next = idx;
    if (cmd.idx_clr) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.slot_ld) begin
      cur_slot <= ul_rdata;
    end
  end

  // Counters and free stack
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= CW'(csl_pkg::SLOTS);
      used_count <= '0;
      for (int i = 0; i < csl_pkg::SLOTS; i++) begin
        free_stack[i] <= SW'(i);
      end
    end else if (cmd.do_add) begin
      free_count <= free_count - CW'(1);
      used_count <= used_count + CW'(1);
    end else if (cmd.del_commit) begin
      used_count <= used_count - CW'(1);
      if (free_count < CW'(csl_pkg::SLOTS)) begin
        free_stack[SW'(free_count)] <= cur_slot;
        free_count <= free_count + CW'(1);
      end
    end
  end

  // Used list: append on add, fill the hole with the tail on delete
  assign ul_we    = cmd.do_add || cmd.del_commit;
  assign ul_waddr = cmd.do_add ? SW'(used_count) : idx;
  assign ul_wdata = cmd.do_add ? pop_slot : ul_rdata;
  assign ul_raddr = cmd.rd_last ? SW'(used_count - CW'(1)) : idx_next;

  csl_ram #(
    .WIDTH (SW),
    .DEPTH (csl_pkg::SLOTS)
  ) u_used_list (
    .clk   (clk),
    .we    (ul_we),
    .waddr (ul_waddr),
    .wdata (ul_wdata),
    .raddr (ul_raddr),
    .rdata (ul_rdata)
  );

  // Slot records, tagged with the region at add time
  assign rec_wdata.id    = id_r;
  assign rec_wdata.ctype = type_r;
  assign rec_wdata.rid   = region_id;
  assign rec_wdata.rtype = region_type;

  csl_ram #(
    .WIDTH ($bits(csl_pkg::slot_rec_t)),
    .DEPTH (csl_pkg::SLOTS)
  ) u_slot_rec (
    .clk   (clk),
    .we    (cmd.do_add),
    .waddr (pop_slot),
    .wdata (rec_wdata),
    .raddr (ul_rdata),
    .rdata (rec_rdata)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_run <= cmd.emit_last;
      case (cmd.emit_kind)
        csl_pkg::EMIT_ADDED: begin
          status            <= 1'b0;
          found             <= 1'b1;
          slot              <= csl_pkg::OUT_SLOT_W'(pop_slot);
          entry_id          <= id_r;
          entry_type        <= type_r;
          entry_region_id   <= region_id;
          entry_region_type <= region_type;
        end
        csl_pkg::EMIT_ENTRY: begin
          status            <= 1'b0;
          found             <= 1'b1;
          slot              <= csl_pkg::OUT_SLOT_W'(cur_slot);
          entry_id          <= rec_rdata.id;
          entry_type        <= rec_rdata.ctype;
          entry_region_id   <= rec_rdata.rid;
          entry_region_type <= rec_rdata.rtype;
        end
        default: begin
          status            <= (cmd.emit_kind == csl_pkg::EMIT_FULL);
          found             <= 1'b0;
          slot              <= '0;
          entry_id          <= '0;
          entry_type        <= '0;
          entry_region_id   <= '0;
          entry_region_type <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/channel_slot_table.sv @@
// Top level of the channel slot table: controller, datapath and checks.
//
//   channel  | handshake            | word
//   ---------+----------------------+--------------------------------------------
//   request  | start, busy          | func, channel_id, channel_type, max_count
//   result   | valid (1-cycle pulse)| status, found, slot, entry_id, entry_type,
//            |                      | entry_region_id, entry_region_type,
//            |                      | last_of_run
//   config   | cfg_we               | cfg_addr, cfg_wdata
//
// A request is taken when start is high and busy is low; one request at a time.
// Add answers at dispatch. Lookup and delete walk the used entries until a match
// or the end; a delete hit then moves the last used entry into the hole. Each
// entry is read from the used list, then the slot record RAM (registered reads).
// A list gives one result word per entry. Reset refills the free stack.
// Results cannot be stalled; each word is valid for exactly one cycle.
`default_nettype none
module channel_slot_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_addr,
  input  wire logic [csl_pkg::ID_W-1:0]    cfg_wdata,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  func,
  input  wire logic [csl_pkg::ID_W-1:0]    channel_id,
  input  wire logic [csl_pkg::TYPE_W-1:0]  channel_type,
  input  wire logic [csl_pkg::MAXC_W-1:0]  max_count,
  output logic                             valid,
  output logic                             status,
  output logic                             found,
  output logic [csl_pkg::OUT_SLOT_W-1:0]   slot,
  output logic [csl_pkg::ID_W-1:0]         entry_id,
  output logic [csl_pkg::TYPE_W-1:0]       entry_type,
  output logic [csl_pkg::ID_W-1:0]         entry_region_id,
  output logic [csl_pkg::TYPE_W-1:0]       entry_region_type,
  output logic                             last_of_run
);

  csl_pkg::ctl_cmd_t  ctl_cmd;
  csl_pkg::ctl_stat_t ctl_stat;

  csl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (ctl_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  csl_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (ctl_cmd),
    .stat              (ctl_stat),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .func              (func),
    .channel_id        (channel_id),
    .channel_type      (channel_type),
    .max_count         (max_count),
    .valid             (valid),
    .status            (status),
    .found             (found),
    .slot              (slot),
    .entry_id          (entry_id),
    .entry_type        (entry_type),
    .entry_region_id   (entry_region_id),
    .entry_region_type (entry_region_type),
    .last_of_run       (last_of_run)
  );

  // An accepted request keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // Every emit command shows up as a result word in the following cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.emit |=> valid)
    else $error("emitted word missing on result port");

  // A table-full report carries no entry and ends the run
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    valid && status |-> !found && last_of_run)
    else $error("table-full word malformed");

  // The final word of a run is never followed directly by another word
  a_run_gap: assert property (@(posedge clk) disable iff (rst)
    valid && last_of_run |=> !valid)
    else $error("word emitted right after end of run");

endmodule
`default_nettype wire
